FILE: src/gsr_pkg.sv
// Shared types and constants for the serial gamepad reader with hat encoder.
// Used by gsr_cfg_regs, gsr_seq and gamepad_serial_reader_hat_encoder.
`default_nettype none

package gsr_pkg;

	localparam int unsigned TICK_W    = 12;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 12;
	localparam int unsigned HAT_W     = 4;
	localparam int unsigned BTN_W     = 4;
	localparam int unsigned NUM_BITS  = 8;
	localparam int unsigned BIDX_W    = 3;

	localparam logic [TICK_W-1:0] LATCH_TICKS_RST = TICK_W'(12);
	localparam logic [TICK_W-1:0] HALF_TICKS_RST  = TICK_W'(6);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LATCH_TICKS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_TICKS  = CFG_IDX_W'(1);

	// hat codes: center, then clockwise from up
	localparam logic [HAT_W-1:0] DIR_NONE = HAT_W'(0);
	localparam logic [HAT_W-1:0] DIR_N    = HAT_W'(1);
	localparam logic [HAT_W-1:0] DIR_NE   = HAT_W'(2);
	localparam logic [HAT_W-1:0] DIR_E    = HAT_W'(3);
	localparam logic [HAT_W-1:0] DIR_SE   = HAT_W'(4);
	localparam logic [HAT_W-1:0] DIR_S    = HAT_W'(5);
	localparam logic [HAT_W-1:0] DIR_SW   = HAT_W'(6);
	localparam logic [HAT_W-1:0] DIR_W    = HAT_W'(7);
	localparam logic [HAT_W-1:0] DIR_NW   = HAT_W'(8);

	localparam logic [HAT_W-1:0] HAT_MAX = DIR_NW;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LATCH = 3'd1,
		PH_WAIT  = 3'd2,
		PH_CLKHI = 3'd3,
		PH_CLKLO = 3'd4
	} phase_t;

	typedef struct packed {
		logic start_read;
		logic data_level;
	} tick_req_t;

	typedef struct packed {
		logic             latch_level;
		logic             clock_level;
		logic             report_valid;
		logic [HAT_W-1:0] hat_code;
		logic [BTN_W-1:0] button_bits;
	} tick_rsp_t;

	typedef struct packed {
		logic [TICK_W-1:0] latch_ticks;
		logic [TICK_W-1:0] half_period_ticks;
	} cfg_t;

endpackage

`default_nettype wire

FILE: src/gsr_cfg_regs.sv
// Configuration registers: latch length and half period in ticks.
// Depends on gsr_pkg.
`default_nettype none

module gsr_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [gsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gsr_pkg::CFG_DAT_W-1:0]  cfg_data,
	output gsr_pkg::cfg_t                       cfg
);

	gsr_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.latch_ticks       <= gsr_pkg::LATCH_TICKS_RST;
			cfg_q.half_period_ticks <= gsr_pkg::HALF_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gsr_pkg::CFG_LATCH_TICKS: begin
					cfg_q.latch_ticks <= cfg_data;
				end
				gsr_pkg::CFG_HALF_TICKS: begin
					cfg_q.half_period_ticks <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/gsr_seq.sv
// Line sequencer: latch, wait/sample, clock high, clock low per bit; hat encode.
// Advances one tick per step_en. Depends on gsr_pkg.
`default_nettype none

module gsr_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step_en,
	input  gsr_pkg::tick_req_t  req,
	input  gsr_pkg::cfg_t       cfg,
	output gsr_pkg::tick_rsp_t  rsp
);

	gsr_pkg::phase_t                  phase_q, phase_d, ph;
	logic [gsr_pkg::TICK_W-1:0]       cnt_q, cnt_d, cnt, cnt_inc, len;
	logic [gsr_pkg::BIDX_W-1:0]       bidx_q, bidx_d, bidx;
	logic [gsr_pkg::NUM_BITS-1:0]     cap_q, cap_d, cap;
	logic                             start_now;
	logic                             phase_end;

	// bits 4..7: up, down, left, right
	function automatic logic [gsr_pkg::HAT_W-1:0] hat_of(
		input logic [gsr_pkg::NUM_BITS-1:0] b
	);
		logic [gsr_pkg::HAT_W-1:0] h;
		h = gsr_pkg::DIR_NONE;
		if (b[4]) begin
			h = b[7] ? gsr_pkg::DIR_NE : (b[6] ? gsr_pkg::DIR_NW : gsr_pkg::DIR_N);
		end else if (b[5]) begin
			h = b[7] ? gsr_pkg::DIR_SE : (b[6] ? gsr_pkg::DIR_SW : gsr_pkg::DIR_S);
		end else if (b[6]) begin
			h = gsr_pkg::DIR_W;
		end else if (b[7]) begin
			h = gsr_pkg::DIR_E;
		end
		return h;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gsr_pkg::PH_IDLE;
			cnt_q   <= '0;
			bidx_q  <= '0;
			cap_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			bidx_q  <= bidx_d;
			cap_q   <= cap_d;
		end
	end

	always_comb begin
		// a start while idle takes effect on this same tick
		start_now = (phase_q == gsr_pkg::PH_IDLE) && req.start_read;
		ph   = start_now ? gsr_pkg::PH_LATCH : phase_q;
		cnt  = start_now ? '0 : cnt_q;
		bidx = start_now ? '0 : bidx_q;
		cap  = start_now ? '0 : cap_q;

		len       = (ph == gsr_pkg::PH_LATCH) ? cfg.latch_ticks : cfg.half_period_ticks;
		cnt_inc   = cnt + gsr_pkg::TICK_W'(1);
		// a length of zero ends the phase at once, like a length of one
		phase_end = ({1'b0, cnt} + (gsr_pkg::TICK_W+1)'(1)) >= {1'b0, len};

		phase_d = ph;
		cnt_d   = cnt;
		bidx_d  = bidx;
		cap_d   = cap;
		rsp     = '0;

		case (ph)
			gsr_pkg::PH_LATCH: begin
				rsp.latch_level = 1'b1;
				cnt_d = phase_end ? '0 : cnt_inc;
				if (phase_end) begin
					phase_d = gsr_pkg::PH_WAIT;
				end
			end
			gsr_pkg::PH_WAIT: begin
				if (cnt == '0 && !req.data_level) begin
					cap_d[bidx] = 1'b1;
				end
				cnt_d = phase_end ? '0 : cnt_inc;
				if (phase_end) begin
					phase_d = gsr_pkg::PH_CLKHI;
				end
			end
			gsr_pkg::PH_CLKHI: begin
				rsp.clock_level = 1'b1;
				cnt_d = phase_end ? '0 : cnt_inc;
				if (phase_end) begin
					phase_d = gsr_pkg::PH_CLKLO;
				end
			end
			gsr_pkg::PH_CLKLO: begin
				cnt_d = phase_end ? '0 : cnt_inc;
				if (phase_end) begin
					if (bidx == gsr_pkg::BIDX_W'(gsr_pkg::NUM_BITS - 1)) begin
						rsp.report_valid = 1'b1;
						rsp.hat_code     = hat_of(cap);
						rsp.button_bits  = cap[gsr_pkg::BTN_W-1:0];
						phase_d          = gsr_pkg::PH_IDLE;
						bidx_d           = '0;
					end else begin
						bidx_d  = bidx + gsr_pkg::BIDX_W'(1);
						phase_d = gsr_pkg::PH_WAIT;
					end
				end
			end
			default: begin
				phase_d = gsr_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/gamepad_serial_reader_hat_encoder.sv
// Serial gamepad reader with hat encoder: top level with tick and result registers.
// Depends on gsr_pkg, gsr_cfg_regs and gsr_seq.
//
// Usage: each request on in_req is one timing tick carrying start_read and
// the sampled data pin level. Every tick gives exactly one response on
// out_rsp: latch and clock drive levels, and report_valid with hat_code and
// button_bits on the tick that finishes the eighth bit (zero otherwise).
// A tick is held in an input register and the sequencer step runs between
// that register and the output register, which holds each response for out_rsp.
// One request is taken every cycle while the output is not stalled: the sequencer
// state lives in flip-flops updated by a single short step, and the input
// register lets the next tick enter while a response waits.
// When out_ready is low, the output holds, the input register fills, and
// in_ready drops after that; nothing is lost or repeated.
// Configuration writes (cfg_index 0 latch_ticks, 1 half_period_ticks) are
// always ready and take effect at once; write them only while idle.
// Reset clears the pipeline, returns the sequencer to idle and loads
// latch_ticks = 12, half_period_ticks = 6.
`default_nettype none

module gamepad_serial_reader_hat_encoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  gsr_pkg::tick_req_t                  in_req,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output gsr_pkg::tick_rsp_t                  out_rsp,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [gsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gsr_pkg::CFG_DAT_W-1:0]  cfg_data
);

	gsr_pkg::cfg_t      cfg;
	gsr_pkg::tick_req_t req_s1;
	gsr_pkg::tick_rsp_t rsp_comb, rsp_s2;
	logic               valid_s1, valid_s2;
	logic               advance;
	logic               step_en;

	// advance the output stage when it is empty or being taken
	assign advance   = !valid_s2 || out_ready;
	assign step_en   = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_rsp   = rsp_s2;

	gsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gsr_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.req     (req_s1),
		.cfg     (cfg),
		.rsp     (rsp_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
		if (step_en) begin
			rsp_s2 <= rsp_comb;
		end
	end

`ifndef SYNTH
	a_lines_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_rsp.latch_level && out_rsp.clock_level))
		else $error("latch and clock driven high together");

	a_report_lines_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rsp.report_valid) |-> (!out_rsp.latch_level && !out_rsp.clock_level))
		else $error("report given while a line is high");

	a_hat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rsp.report_valid) |-> (out_rsp.hat_code <= gsr_pkg::HAT_MAX))
		else $error("hat code out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled while pipeline has room");

	a_no_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_rsp.report_valid) |->
			(out_rsp.hat_code == '0 && out_rsp.button_bits == '0))
		else $error("report fields set without a report");
`endif

endmodule

`default_nettype wire
